[rtl/rs_pkg.sv]
// Shared constants, types and controller state encoding for the reservoir sampler.
package rs_pkg;

	localparam int DEPTH  = 64;                 // reservoir slots
	localparam int ITEM_W = 32;                 // stored item width
	localparam int SLOT_W = $clog2(DEPTH);      // slot index width
	localparam int KW     = $clog2(DEPTH + 1);  // width holding 0..DEPTH
	localparam int CNT_W  = 32;                 // seen-count width
	localparam int RND_W  = 31;                 // random word width
	localparam int CFG_W  = 7;                  // sample_size register width
	localparam int STEP_W = $clog2(RND_W);      // remainder step counter width

	localparam logic CMD_PUSH   = 1'b0;
	localparam logic CMD_FINISH = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_MOD,
		S_DUMP_RD,
		S_DUMP_OUT
	} rs_state_t;

	// controller -> datapath
	typedef struct packed {
		logic latch_in;   // capture an accepted input word
		logic fill_wr;    // write item into next free slot, bump count
		logic mod_start;  // bump count (saturating) and start remainder
		logic repl_wr;    // conditional replace with remainder slot
		logic rd_issue;   // read reservoir at dump pointer
		logic out_load;   // load output register, advance dump pointer
		logic dump_clr;   // clear seen-count after a dump
	} rs_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic finish;      // latched word is a finish command
		logic fill;        // count below k, slot fill phase
		logic mod_done;    // remainder ready
		logic dump_empty;  // nothing to dump
		logic dump_last;   // pointer at the final slot of the dump
		logic out_free;    // output register can take a word
	} rs_stat_t;

endpackage

[rtl/rs_modu.sv]
// Bit-serial restoring remainder unit: one dividend bit per cycle.
module rs_modu
	import rs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [RND_W-1:0] dividend,
	input  logic [CNT_W-1:0] divisor,
	output logic             done,
	output logic [CNT_W-1:0] remainder
);

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] step_q;
	logic [RND_W-1:0]  dvd_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    diff;

	// shift in next dividend bit, subtract when it fits
	always_comb begin
		trial = {rem_q, dvd_q[RND_W-1]};
		diff  = trial - {1'b0, dvs_q};
	end

	// control: step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= busy_q && !start && (step_q == '0);
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(RND_W - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// datapath: partial remainder and dividend shift
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[RND_W-2:0], 1'b0};
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= diff[CNT_W-1:0];
			end else begin
				rem_q <= trial[CNT_W-1:0];
			end
		end
	end

	assign done      = done_q;
	assign remainder = rem_q;

endmodule

[rtl/rs_dpath.sv]
// Datapath: input capture, seen-count, reservoir memory, remainder unit, output register.
module rs_dpath
	import rs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  rs_cmd_t          cmd,
	output rs_stat_t         stat,
	input  logic             in_command,
	input  logic [31:0]      in_item,
	input  logic [RND_W-1:0] in_random,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [31:0]      out_value,
	output logic             out_last
);

	logic              cmd_q;
	logic [ITEM_W-1:0] item_q;
	logic [RND_W-1:0]  rnd_q;
	logic [CNT_W-1:0]  count_q;
	logic [CFG_W-1:0]  ssize_q;
	logic [SLOT_W-1:0] ptr_q;
	logic [ITEM_W-1:0] mem_q [DEPTH];
	logic [ITEM_W-1:0] rdata_q;
	logic              ovalid_q;
	logic [31:0]       odata_q;
	logic              olast_q;

	logic [KW-1:0]     k_eff;
	logic [KW-1:0]     n_dump;
	logic [CNT_W-1:0]  count_inc;
	logic              below_k;
	logic              mod_done;
	logic [CNT_W-1:0]  rem;
	logic              rem_hit;
	logic              mem_we;
	logic [SLOT_W-1:0] mem_wa;

	// effective sample size: clamp to 1..DEPTH
	always_comb begin
		if (ssize_q == '0) begin
			k_eff = KW'(1);
		end else if ({{(KW + CFG_W){1'b0}}, ssize_q} > (KW + 2 * CFG_W)'(DEPTH)) begin
			k_eff = KW'(DEPTH);
		end else begin
			k_eff = KW'(ssize_q);
		end
	end

	always_comb begin
		below_k   = count_q < CNT_W'(k_eff);
		n_dump    = below_k ? KW'(count_q) : k_eff;
		count_inc = (count_q == '1) ? count_q : count_q + 1'b1;
		rem_hit   = rem < CNT_W'(k_eff);
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ssize_q <= CFG_W'(1);
		end else if (cfg_we) begin
			ssize_q <= cfg_wdata;
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			cmd_q  <= in_command;
			item_q <= ITEM_W'(in_item);
			rnd_q  <= in_random;
		end
	end

	// seen-count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.dump_clr) begin
			count_q <= '0;
		end else if (cmd.fill_wr || cmd.mod_start) begin
			count_q <= count_inc;
		end
	end

	// dump pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (cmd.latch_in) begin
			ptr_q <= '0;
		end else if (cmd.out_load) begin
			ptr_q <= ptr_q + 1'b1;
		end
	end

	rs_modu u_modu (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.mod_start),
		.dividend  (rnd_q),
		.divisor   (count_inc),
		.done      (mod_done),
		.remainder (rem)
	);

	// reservoir memory: one write port, one registered read port
	assign mem_we = cmd.fill_wr || (cmd.repl_wr && rem_hit);
	assign mem_wa = cmd.fill_wr ? count_q[SLOT_W-1:0] : rem[SLOT_W-1:0];

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_wa] <= item_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_issue) begin
			rdata_q <= mem_q[ptr_q];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			ovalid_q <= 1'b1;
		end else if (out_ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			odata_q <= 32'(rdata_q);
			olast_q <= stat.dump_last;
		end
	end

	// status back to the controller
	always_comb begin
		stat.finish     = cmd_q == CMD_FINISH;
		stat.fill       = below_k;
		stat.mod_done   = mod_done;
		stat.dump_empty = n_dump == '0;
		stat.dump_last  = (KW'(ptr_q) + 1'b1) == n_dump;
		stat.out_free   = !ovalid_q || out_ready;
	end

	assign out_valid = ovalid_q;
	assign out_value = odata_q;
	assign out_last  = olast_q;

endmodule

[rtl/rs_ctrl.sv]
// Controller state machine sequencing push, replace and dump.
module rs_ctrl
	import rs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  rs_stat_t stat,
	output rs_cmd_t  cmd
);

	rs_state_t state_q;
	rs_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (stat.finish) begin
					state_d = stat.dump_empty ? S_IDLE : S_DUMP_RD;
				end else begin
					state_d = stat.fill ? S_IDLE : S_MOD;
				end
			end
			S_MOD: begin
				if (stat.mod_done) begin
					state_d = S_IDLE;
				end
			end
			S_DUMP_RD: begin
				state_d = S_DUMP_OUT;
			end
			S_DUMP_OUT: begin
				if (stat.out_free) begin
					state_d = stat.dump_last ? S_IDLE : S_DUMP_RD;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready     = 1'b1;
				cmd.latch_in = in_valid;
			end
			S_DECODE: begin
				if (stat.finish) begin
					cmd.dump_clr = stat.dump_empty;
				end else begin
					cmd.fill_wr   = stat.fill;
					cmd.mod_start = !stat.fill;
				end
			end
			S_MOD: begin
				cmd.repl_wr = stat.mod_done;
			end
			S_DUMP_RD: begin
				cmd.rd_issue = 1'b1;
			end
			S_DUMP_OUT: begin
				cmd.out_load = stat.out_free;
				cmd.dump_clr = stat.out_free && stat.dump_last;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

[rtl/reservoir_sampler_core.sv]
// Top level of the reservoir sampler: controller plus datapath.
//
//  channel  | dir | handshake              | payload
//  ---------+-----+------------------------+------------------------------------------
//  s_*      | in  | s_tvalid / s_tready    | s_tdata: item_value, random_word; s_tuser: command
//  m_*      | out | m_tvalid / m_tready    | m_tdata: sample_value; m_tlast: is_last
//  cfg_*    | in  | cfg_valid / cfg_ready  | cfg_data: sample_size
//
// A push during the fill phase passes through IDLE and DECODE. A push past the fill phase
// also waits in MOD for the bit-serial remainder unit (one random bit per cycle).
// A finish reads and outputs each dumped word in turn (memory read, then output load);
// a stalled m_tready holds the dump and the input side stays closed until it ends.
// arst_n clears the count, the controller and the output valid; sample_size resets to 1.
module reservoir_sampler_core
	import rs_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [63:0]      s_tdata,    // [31:0] item_value, [62:32] random_word, [63] zero
	input  logic             s_tuser,    // [0] command
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [31:0]      m_tdata,    // [31:0] sample_value
	output logic             m_tlast,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CFG_W-1:0] cfg_data
);

	rs_cmd_t  cmd;
	rs_stat_t stat;

	assign cfg_ready = 1'b1;

	rs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	rs_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_command (s_tuser),
		.in_item    (s_tdata[31:0]),
		.in_random  (s_tdata[32 +: RND_W]),
		.cfg_we     (cfg_valid),
		.cfg_wdata  (cfg_data),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_value  (m_tdata),
		.out_last   (m_tlast)
	);

endmodule

[dv/reservoir_sampler_core_test.sv]
// Self-checking testbench for reservoir_sampler_core: stream stimulus, reservoir predictor, dump checker.
module reservoir_sampler_core_test;
	import rs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int QUIET_LIMIT = 2000;  // cycles with no accepted word before giving up
	localparam int SETTLE      = 60;    // cycles to cover a remainder pass after the last word
	localparam int HOLD_CYCLES = 300;   // long receiver hold-off for the backpressure test
	localparam int RANDOM_WORDS = 360;

	typedef struct packed {
		logic [31:0] value;
		logic        last;
	} sample_t;

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [63:0]      s_tdata;   // [31:0] item_value, [62:32] random_word, [63] zero
	logic             s_tuser;   // [0] command
	logic             m_tvalid;
	logic             m_tready;
	logic [31:0]      m_tdata;   // [31:0] sample_value
	logic             m_tlast;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [CFG_W-1:0] cfg_data;

	// predictor state
	logic [31:0]      slot_store [DEPTH];
	logic [31:0]      stream_count;
	logic [CFG_W-1:0] size_reg;
	sample_t          pending_samples[$];

	int  mismatch_count;
	int  words_sent;
	bit  gaps_on;
	bit  hold_request;

	reservoir_sampler_core u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// k as the block uses it: clamped to 1..DEPTH
	function automatic int unsigned active_size();
		int unsigned k;
		k = size_reg;
		if (k < 1) k = 1;
		if (k > DEPTH) k = DEPTH;
		return k;
	endfunction

	// Algorithm R step for one accepted word; a finish queues the dump
	task automatic update_reservoir(input logic cmd, input logic [31:0] val,
			input logic [RND_W-1:0] rnd);
		int unsigned k;
		int unsigned n;
		logic [31:0] slot;
		sample_t s;
		k = active_size();
		if (cmd == CMD_PUSH) begin
			if (stream_count < k) begin
				slot_store[stream_count] = val;
				stream_count++;
			end else begin
				if (stream_count != 32'hFFFF_FFFF) stream_count++;
				slot = {1'b0, rnd} % stream_count;
				if (slot < k) slot_store[slot] = val;
			end
		end else begin
			n = (stream_count < k) ? stream_count : k;
			for (int j = 0; j < n; j++) begin
				s.value = slot_store[j];
				s.last  = (j + 1 == n);
				pending_samples.push_back(s);
			end
			stream_count = '0;
		end
	endtask

	// offer one word after a random gap and wait for it to be taken
	task automatic send_word(input logic cmd, input logic [31:0] val,
			input logic [RND_W-1:0] rnd);
		int gap;
		gap = gaps_on ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {1'b0, rnd, val};
		s_tuser  <= cmd;
		do @(posedge clk); while (!s_tready);
		update_reservoir(cmd, val, rnd);
		words_sent++;
	endtask

	task automatic push_word(input logic [31:0] val, input logic [RND_W-1:0] rnd);
		send_word(CMD_PUSH, val, rnd);
	endtask

	task automatic finish_stream();
		send_word(CMD_FINISH, $urandom(), RND_W'($urandom()));
	endtask

	// drain all expected words, then let a trailing remainder pass complete
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_samples.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_sample_size(input logic [CFG_W-1:0] val);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		size_reg = val;
	endtask

	// reset value k=1: empty dump, replacement at slot 0, double finish
	task automatic test_single_slot();
		finish_stream();
		push_word(32'h0000_0000, '0);
		push_word(32'hFFFF_FFFF, '1);
		push_word(32'hA5A5_A5A5, '0);
		finish_stream();
		finish_stream();
	endtask

	// partial dump below k, then full fill and replacements
	task automatic test_fill_and_replace();
		write_sample_size(7'd4);
		push_word(32'h1111_1111, '1);
		push_word(32'h2222_2222, '0);
		push_word(32'h3333_3333, 31'h5555_5555);
		finish_stream();
		push_word(32'h8000_0000, '0);
		push_word(32'h0000_0001, '1);
		push_word(32'h7FFF_FFFE, 31'h2AAA_AAAA);
		push_word(32'hDEAD_BEEF, '0);
		push_word(32'h0F0F_0F0F, '0);
		push_word(32'hF0F0_F0F0, '1);
		send_word(CMD_FINISH, 32'hFFFF_FFFF, '1);
	endtask

	// a size of zero behaves as one slot
	task automatic test_zero_size();
		write_sample_size('0);
		push_word(32'hCAFE_0001, 31'h0000_0001);
		push_word(32'hCAFE_0002, 31'h0000_0002);
		finish_stream();
	endtask

	// random streams over random sizes, extremes first
	task automatic test_random_streams();
		int phase;
		int pushes;
		int unsigned k;
		logic [CFG_W-1:0] sz;
		logic [RND_W-1:0] rnd;
		phase = 0;
		while (words_sent < RANDOM_WORDS) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			case (phase)
				0: sz = '1;
				1: sz = 7'(DEPTH);
				2: sz = 7'd1;
				default: begin
					case ($urandom_range(0, 9))
						0: sz = '0;
						1: sz = '1;
						2: sz = 7'(DEPTH);
						3: sz = 7'($urandom_range(DEPTH + 1, 127));
						default: sz = 7'($urandom_range(1, 16));
					endcase
				end
			endcase
			if (phase < 3 || $urandom_range(0, 1)) write_sample_size(sz);
			k = active_size();
			pushes = (phase < 2) ? k + 8 : $urandom_range(0, 2 * k + 4);
			for (int i = 0; i < pushes; i++) begin
				// mix full-range draws with small ones that often hit a slot
				case ($urandom_range(0, 5))
					0: rnd = '0;
					1: rnd = '1;
					2: rnd = RND_W'($urandom_range(0, 2 * k + 8));
					default: rnd = RND_W'($urandom());
				endcase
				push_word($urandom(), rnd);
			end
			finish_stream();
			if ($urandom_range(0, 7) == 0) finish_stream();
			phase++;
		end
	endtask

	// long receiver hold during a full dump while pushes keep coming
	task automatic test_backpressure();
		write_sample_size(7'(DEPTH));
		gaps_on = 1'b0;
		for (int i = 0; i < DEPTH + 6; i++) push_word($urandom(), RND_W'($urandom()));
		hold_request = 1'b1;
		finish_stream();
		for (int i = 0; i < 8; i++) push_word($urandom(), RND_W'($urandom()));
		finish_stream();
		gaps_on = 1'b1;
	endtask

	// receiver: random stall before each word, plus one long hold on request
	initial begin
		int stall;
		m_tready <= 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (hold_request) begin
				hold_request = 1'b0;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stall = gaps_on ? $urandom_range(0, 4) : 0;
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	// compare each dumped word with the oldest expected sample
	always @(posedge clk) begin
		sample_t exp_s;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_samples.size() == 0) begin
				$display("%0t: unexpected word: expected none, actual value %h last %0b",
					$time, m_tdata, m_tlast);
				mismatch_count++;
			end else begin
				exp_s = pending_samples.pop_front();
				if (m_tdata !== exp_s.value) begin
					$display("%0t: sample_value mismatch: expected %h, actual %h",
						$time, exp_s.value, m_tdata);
					mismatch_count++;
				end
				if (m_tlast !== exp_s.last) begin
					$display("%0t: is_last mismatch: expected %0b, actual %0b",
						$time, exp_s.last, m_tlast);
					mismatch_count++;
				end
			end
		end
	end

	// watchdog on cycles where no channel moves a word
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: timeout, %0d samples still expected", $time, pending_samples.size());
		$display("reservoir_sampler_core_test: FAIL");
		$finish;
	end

	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= CMD_PUSH;
		cfg_valid <= 1'b0;
		cfg_data  <= '0;
		mismatch_count = 0;
		words_sent     = 0;
		gaps_on        = 1'b1;
		hold_request   = 1'b0;
		stream_count   = '0;
		size_reg       = 7'd1;
		for (int i = 0; i < DEPTH; i++) slot_store[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_single_slot();
		test_fill_and_replace();
		test_zero_size();
		test_random_streams();
		test_backpressure();
		wait_idle();

		if (mismatch_count == 0 && pending_samples.size() == 0)
			$display("reservoir_sampler_core_test: PASS");
		else
			$display("reservoir_sampler_core_test: FAIL");
		$finish;
	end

endmodule
